// ----- rtl/gia_pkg.sv -----
// ----------------------------------------------------------------------------
// gia_pkg
// shared types and codes of the generational id allocator
// ----------------------------------------------------------------------------
package gia_pkg;

	// width of the min_free configuration register
	localparam int unsigned MIN_FREE_W = 13;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_ALIVE   = 2'd2,
		OP_GET     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EXHAUSTED  = 2'd1,
		ST_UNKNOWN    = 2'd2,
		ST_QUEUE_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_READ2,
		S_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture request, read table and queue head
		logic rd_reuse; // read table at the popped queue entry
		logic exec;     // commit updates and load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic reuse_create; // captured create will pop the free queue
		logic out_free;     // result register can take a new result
	} sts_t;

endpackage

// ----- rtl/gia_req_if.sv -----
// ----------------------------------------------------------------------------
// gia_req_if
// request channel: op, entity index and version with valid/ready
// ----------------------------------------------------------------------------
interface gia_req_if #(
	parameter int unsigned INDEX_BITS   = 12,
	parameter int unsigned VERSION_BITS = 8
);
	logic                    valid;
	logic                    ready;
	gia_pkg::op_t            op;
	logic [INDEX_BITS-1:0]   entity_index;
	logic [VERSION_BITS-1:0] entity_version;

	modport source (output valid, input ready, output op, output entity_index,
		output entity_version);
	modport sink (input valid, output ready, input op, input entity_index,
		input entity_version);
endinterface

// ----- rtl/gia_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gia_rsp_if
// result channel: handle, alive flag and status with valid/ready
// ----------------------------------------------------------------------------
interface gia_rsp_if #(
	parameter int unsigned INDEX_BITS   = 12,
	parameter int unsigned VERSION_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic [INDEX_BITS-1:0]   result_index;
	logic [VERSION_BITS-1:0] result_version;
	logic                    alive;
	gia_pkg::status_t        status;

	modport source (output valid, input ready, output result_index,
		output result_version, output alive, output status);
	modport sink (input valid, output ready, input result_index,
		input result_version, input alive, input status);
endinterface

// ----- rtl/gia_ctrl.sv -----
// ----------------------------------------------------------------------------
// gia_ctrl
// request sequencer: accept, memory reads, execute
// ----------------------------------------------------------------------------
module gia_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gia_pkg::sts_t sts,
	output gia_pkg::cmd_t cmd
);
	import gia_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_READ;
			end
			S_READ: begin
				state_d = sts.reuse_create ? S_READ2 : S_EXEC;
			end
			S_READ2: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		cmd.load     = 1'b0;
		cmd.rd_reuse = 1'b0;
		cmd.exec     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_READ: begin
				cmd.rd_reuse = sts.reuse_create;
			end
			S_READ2: begin
			end
			S_EXEC: begin
				cmd.exec = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/gia_datapath.sv -----
// ----------------------------------------------------------------------------
// gia_datapath
// version table, free queue, counters and result register
// ----------------------------------------------------------------------------
module gia_datapath #(
	parameter int unsigned INDEX_BITS   = 12,
	parameter int unsigned VERSION_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gia_pkg::MIN_FREE_W-1:0]      cfg_wdata,
	input  gia_pkg::op_t                        req_op,
	input  logic [INDEX_BITS-1:0]               req_index,
	input  logic [VERSION_BITS-1:0]             req_version,
	input  gia_pkg::cmd_t                       cmd,
	output gia_pkg::sts_t                       sts,
	gia_rsp_if.source                           rsp
);
	import gia_pkg::*;

	localparam int unsigned DEPTH = 1 << INDEX_BITS;
	localparam int unsigned CW    = (INDEX_BITS + 1 > MIN_FREE_W) ?
		INDEX_BITS + 1 : MIN_FREE_W;

	logic [VERSION_BITS-1:0] vtab [DEPTH];
	logic [INDEX_BITS-1:0]   fq   [DEPTH];

	logic [VERSION_BITS-1:0] tbl_rdata_q;
	logic [INDEX_BITS-1:0]   fq_rdata_q;

	op_t                     op_q;
	logic [INDEX_BITS-1:0]   idx_q;
	logic [VERSION_BITS-1:0] ver_q;

	logic [INDEX_BITS:0]     alloc_q;
	logic [INDEX_BITS:0]     count_q;
	logic [INDEX_BITS-1:0]   head_q;
	logic [INDEX_BITS-1:0]   tail_q;
	logic [MIN_FREE_W-1:0]   min_free_q;

	logic                    out_valid_q;
	logic [INDEX_BITS-1:0]   out_index_q;
	logic [VERSION_BITS-1:0] out_version_q;
	logic                    out_alive_q;
	status_t                 out_status_q;

	logic                    reuse;
	logic                    known;
	logic [VERSION_BITS-1:0] next_ver;

	logic                    tbl_we;
	logic [INDEX_BITS-1:0]   tbl_waddr;
	logic [VERSION_BITS-1:0] tbl_wdata;
	logic                    fq_we;
	logic                    pop;
	logic                    take_new;

	logic [INDEX_BITS-1:0]   res_index;
	logic [VERSION_BITS-1:0] res_version;
	logic                    res_alive;
	status_t                 res_status;

	assign reuse    = CW'(count_q) > CW'(min_free_q);
	assign known    = {1'b0, idx_q} < alloc_q;
	assign next_ver = tbl_rdata_q + VERSION_BITS'(1);

	assign sts.reuse_create = (op_q == OP_CREATE) && reuse;
	assign sts.out_free     = !out_valid_q || rsp.ready;

	always_comb begin
		tbl_we      = 1'b0;
		tbl_waddr   = idx_q;
		tbl_wdata   = next_ver;
		fq_we       = 1'b0;
		pop         = 1'b0;
		take_new    = 1'b0;
		res_index   = idx_q;
		res_version = '0;
		res_alive   = 1'b0;
		res_status  = ST_OK;
		case (op_q)
			OP_CREATE: begin
				if (reuse) begin
					pop         = 1'b1;
					res_index   = fq_rdata_q;
					res_version = tbl_rdata_q;
					res_alive   = 1'b1;
				end else if (!alloc_q[INDEX_BITS]) begin
					take_new    = 1'b1;
					tbl_we      = 1'b1;
					tbl_waddr   = alloc_q[INDEX_BITS-1:0];
					tbl_wdata   = '0;
					res_index   = alloc_q[INDEX_BITS-1:0];
					res_alive   = 1'b1;
				end else begin
					res_index   = '0;
					res_status  = ST_EXHAUSTED;
				end
			end
			OP_DESTROY: begin
				if (!known) begin
					res_status  = ST_UNKNOWN;
				end else begin
					tbl_we      = 1'b1;
					res_version = next_ver;
					if (count_q[INDEX_BITS]) res_status = ST_QUEUE_FULL;
					else fq_we = 1'b1;
				end
			end
			OP_ALIVE: begin
				if (!known) begin
					res_status  = ST_UNKNOWN;
				end else begin
					res_version = tbl_rdata_q;
					res_alive   = (tbl_rdata_q == ver_q);
				end
			end
			default: begin
				if (!known) res_status = ST_UNKNOWN;
				else res_version = tbl_rdata_q;
			end
		endcase
	end

	// memories: registered reads, writes on execute
	always_ff @(posedge clk) begin
		if (cmd.load) tbl_rdata_q <= vtab[req_index];
		else if (cmd.rd_reuse) tbl_rdata_q <= vtab[fq_rdata_q];
		if (cmd.exec && tbl_we) vtab[tbl_waddr] <= tbl_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) fq_rdata_q <= fq[head_q];
		if (cmd.exec && fq_we) fq[tail_q] <= idx_q;
	end

	// captured request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_op;
			idx_q <= req_index;
			ver_q <= req_version;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q    <= '0;
			count_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			min_free_q <= '0;
		end else begin
			if (cfg_we) min_free_q <= cfg_wdata;
			if (cmd.exec) begin
				if (take_new) alloc_q <= alloc_q + (INDEX_BITS + 1)'(1);
				if (pop) begin
					head_q  <= head_q + INDEX_BITS'(1);
					count_q <= count_q - (INDEX_BITS + 1)'(1);
				end
				if (fq_we) begin
					tail_q  <= tail_q + INDEX_BITS'(1);
					count_q <= count_q + (INDEX_BITS + 1)'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_index_q   <= res_index;
			out_version_q <= res_version;
			out_alive_q   <= res_alive;
			out_status_q  <= res_status;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_index   = out_index_q;
	assign rsp.result_version = out_version_q;
	assign rsp.alive          = out_alive_q;
	assign rsp.status         = out_status_q;

endmodule

// ----- rtl/generational_id_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// generational_id_allocator_unit
// hands out index/version handles, recycles destroyed indexes through a fifo
// ----------------------------------------------------------------------------
// One request is in flight at a time. A request is taken in the idle cycle,
// the version table and the free queue head are read in the next cycle
// (both are synchronous-read memories), and the result is produced in the
// execute cycle; a create that reuses a freed index passes through a second
// read state first, since its version lookup needs the popped index from
// the queue. The result sits in an output register, so the next request is
// taken while the previous result still waits; a stalled result register
// holds the block in execute. Memories are not cleared after reset: table
// data is only used below the allocated count and queue data only while it
// holds entries, so no clearing pass is needed. The user must write min_free
// only while the block is idle; the block itself does not enforce it.
module generational_id_allocator_unit #(
	parameter int unsigned INDEX_BITS   = 12,
	parameter int unsigned VERSION_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// min_free register write
	input  logic                           cfg_we,
	input  logic [gia_pkg::MIN_FREE_W-1:0] cfg_wdata,
	// request and result channels
	gia_req_if.sink                        req,
	gia_rsp_if.source                      rsp
);
	import gia_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: idle / read / second read / execute
	gia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tables, counters and result register
	gia_datapath #(
		.INDEX_BITS   (INDEX_BITS),
		.VERSION_BITS (VERSION_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_op      (req.op),
		.req_index   (req.entity_index),
		.req_version (req.entity_version),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp)
	);

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the generational id allocator unit
// ----------------------------------------------------------------------------
// Requests come from a queue that the stimulus process fills and go out
// through a clocked driver with random gaps. A clocked monitor runs a
// handle-table predictor on every accepted request and checks each returned
// result against the oldest prediction. The run walks through several
// min_free settings:
// - a directed opening covers unknown indexes, reuse and double destroy
// - a bulk phase hands out a long run of fresh indexes with reuse held off,
//   then frees many of them
// - random phases mix all four operations
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gia_pkg::*;

	localparam int unsigned IDX_W     = 12;
	localparam int unsigned VER_W     = 8;
	localparam int unsigned NUM_IDS   = 1 << IDX_W;
	localparam int unsigned MAX_MIN   = 4096;
	localparam int unsigned DRAIN_CYC = 8;
	localparam int unsigned CYC_LIMIT = 5_000_000;
	localparam int unsigned BULK_NEW  = 500;
	localparam int unsigned BULK_FREE = 400;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] index;
		logic [VER_W-1:0] version;
	} handle_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [VER_W-1:0] version;
		logic             alive;
		status_t          status;
	} handle_rsp_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [MIN_FREE_W-1:0] cfg_wdata;

	gia_req_if #(.INDEX_BITS(IDX_W), .VERSION_BITS(VER_W)) req_if ();
	gia_rsp_if #(.INDEX_BITS(IDX_W), .VERSION_BITS(VER_W)) rsp_if ();

	generational_id_allocator_unit #(
		.INDEX_BITS  (IDX_W),
		.VERSION_BITS(VER_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	// requests waiting for the driver, results waiting for the dut
	handle_req_t req_pending[$];
	handle_rsp_t rsp_expected[$];

	// shadow of the allocator: version table, recycle fifo, counters
	logic [VER_W-1:0] shadow_ver[NUM_IDS];
	logic [IDX_W-1:0] recycle_fifo[NUM_IDS];
	logic [IDX_W-1:0] recycle_head;
	logic [IDX_W-1:0] recycle_tail;
	int unsigned      recycle_cnt;
	int unsigned      alloc_cnt;
	int unsigned      shadow_min_free;

	int unsigned err_cnt;
	int unsigned cyc_cnt;
	logic        req_fire;
	int unsigned req_gap;
	int unsigned req_calm;
	int unsigned rsp_stall;
	int unsigned rsp_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short idles, a few long ones, and now and then a calm stretch
	// of back-to-back traffic
	function automatic int unsigned idle_len(inout int unsigned calm);
		int unsigned k;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		k = $urandom_range(0, 99);
		if (k < 2) begin
			calm = $urandom_range(30, 80);
			return 0;
		end
		if (k < 55)
			return 0;
		if (k < 88)
			return $urandom_range(1, 3);
		if (k < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// work out the result of one request and advance the shadow state
	function automatic handle_rsp_t allocate_or_lookup(input handle_req_t r);
		handle_rsp_t res;
		logic [IDX_W-1:0] slot;
		res.index   = r.index;
		res.version = '0;
		res.alive   = 1'b0;
		res.status  = ST_OK;
		if (r.op == OP_CREATE) begin
			if (recycle_cnt > shadow_min_free) begin
				// reuse the oldest freed index, version as left by its destroy
				slot = recycle_fifo[recycle_head];
				recycle_head++;
				recycle_cnt--;
				res.index   = slot;
				res.version = shadow_ver[slot];
				res.alive   = 1'b1;
			end else if (alloc_cnt < NUM_IDS) begin
				// fresh index, starts at version zero
				slot = alloc_cnt[IDX_W-1:0];
				shadow_ver[slot] = '0;
				alloc_cnt++;
				res.index = slot;
				res.alive = 1'b1;
			end else begin
				// no fallback on the fifo once every index is out
				res.index  = '0;
				res.status = ST_EXHAUSTED;
			end
		end else if (r.index >= alloc_cnt) begin
			res.status = ST_UNKNOWN;
		end else begin
			case (r.op)
				OP_DESTROY: begin
					// version bumps even when the fifo push gets dropped
					shadow_ver[r.index] = shadow_ver[r.index] + 1'b1;
					res.version = shadow_ver[r.index];
					if (recycle_cnt >= NUM_IDS) begin
						res.status = ST_QUEUE_FULL;
					end else begin
						recycle_fifo[recycle_tail] = r.index;
						recycle_tail++;
						recycle_cnt++;
					end
				end
				OP_ALIVE: begin
					res.version = shadow_ver[r.index];
					res.alive   = (shadow_ver[r.index] == r.version);
				end
				default: begin
					res.version = shadow_ver[r.index];
				end
			endcase
		end
		return res;
	endfunction

	// request driver: new values at the falling edge, valid held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_fire) begin
			if (req_gap > 0) begin
				req_gap--;
				req_if.valid <= 1'b0;
			end else if (req_pending.size() > 0) begin
				req_if.op             <= req_pending[0].op;
				req_if.entity_index   <= req_pending[0].index;
				req_if.entity_version <= req_pending[0].version;
				req_if.valid          <= 1'b1;
				req_pending.delete(0);
				req_gap = idle_len(req_calm);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (rsp_stall > 0) begin
			rsp_stall--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
			rsp_stall = idle_len(rsp_calm);
		end
	end

	// monitor: check results first, then predict the request taken this edge
	always @(posedge clk) begin
		handle_req_t got_req;
		handle_rsp_t exp_rsp;
		if (!arst_n) begin
			req_fire <= 1'b0;
		end else begin
			cyc_cnt++;
			if (cyc_cnt >= CYC_LIMIT) begin
				$display("%0t timeout after %0d cycles", $time, cyc_cnt);
				$display("== FAIL ==");
				$finish;
			end else begin
				if (cfg_we)
					shadow_min_free = cfg_wdata;
				if (rsp_if.valid && rsp_if.ready) begin
					if (rsp_expected.size() == 0) begin
						err_cnt++;
						$display("%0t unexpected result idx=%0d ver=%0d alive=%0b st=%0d",
							$time, rsp_if.result_index, rsp_if.result_version,
							rsp_if.alive, rsp_if.status);
					end else begin
						exp_rsp = rsp_expected[0];
						rsp_expected.delete(0);
						if (rsp_if.result_index !== exp_rsp.index) begin
							err_cnt++;
							$display("%0t result_index expected %0d got %0d",
								$time, exp_rsp.index, rsp_if.result_index);
						end
						if (rsp_if.result_version !== exp_rsp.version) begin
							err_cnt++;
							$display("%0t result_version expected %0d got %0d",
								$time, exp_rsp.version, rsp_if.result_version);
						end
						if (rsp_if.alive !== exp_rsp.alive) begin
							err_cnt++;
							$display("%0t alive expected %0b got %0b",
								$time, exp_rsp.alive, rsp_if.alive);
						end
						if (rsp_if.status !== exp_rsp.status) begin
							err_cnt++;
							$display("%0t status expected %0d got %0d",
								$time, exp_rsp.status, rsp_if.status);
						end
					end
				end
				if (req_if.valid && req_if.ready) begin
					got_req.op      = req_if.op;
					got_req.index   = req_if.entity_index;
					got_req.version = req_if.entity_version;
					rsp_expected.insert(rsp_expected.size(),
						allocate_or_lookup(got_req));
				end
				req_fire <= req_if.valid && req_if.ready;
			end
		end
	end

	task automatic queue_req(input op_t op, input int unsigned idx, input int unsigned ver);
		handle_req_t r;
		r.op      = op;
		r.index   = idx[IDX_W-1:0];
		r.version = ver[VER_W-1:0];
		req_pending.insert(req_pending.size(), r);
	endtask

	// wait until every request went out and every result came back
	task automatic wait_idle();
		while (req_pending.size() != 0 || req_if.valid || rsp_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// min_free is only written with the block idle
	task automatic set_min_free(input int unsigned v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[MIN_FREE_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// random mix, fed a few at a time so that alive checks can aim at the
	// current version of an index; indexes lean toward a small hot set
	task automatic random_reqs(input int unsigned n);
		int unsigned k;
		int unsigned idx;
		op_t         op;
		repeat (n) begin
			while (req_pending.size() >= 2)
				@(posedge clk);
			k  = $urandom_range(0, 99);
			op = (k < 35) ? OP_CREATE : (k < 70) ? OP_DESTROY : (k < 85) ? OP_ALIVE : OP_GET;
			k  = $urandom_range(0, 99);
			if (k < 60)
				idx = $urandom_range(0, 15);
			else if (k < 85)
				idx = $urandom_range(0, NUM_IDS - 1);
			else
				idx = $urandom_range(NUM_IDS - 16, NUM_IDS - 1);
			if ($urandom_range(0, 1) == 1 && idx < alloc_cnt)
				queue_req(op, idx, shadow_ver[idx]);
			else
				queue_req(op, idx, $urandom_range(0, (1 << VER_W) - 1));
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		req_if.valid          = 1'b0;
		req_if.op             = OP_CREATE;
		req_if.entity_index   = '0;
		req_if.entity_version = '0;
		rsp_if.ready          = 1'b0;
		req_fire              = 1'b0;
		req_gap               = 0;
		req_calm              = 0;
		rsp_stall             = 0;
		rsp_calm              = 0;
		err_cnt               = 0;
		cyc_cnt               = 0;
		recycle_head          = '0;
		recycle_tail          = '0;
		recycle_cnt           = 0;
		alloc_cnt             = 0;
		shadow_min_free       = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed opening, min_free at zero
		set_min_free(0);
		queue_req(OP_GET, 0, 0);                            // nothing allocated yet
		queue_req(OP_ALIVE, NUM_IDS - 1, (1 << VER_W) - 1);
		queue_req(OP_DESTROY, 0, 0);
		queue_req(OP_CREATE, 0, 0);                         // fresh 0, 1, 2
		queue_req(OP_CREATE, 0, 0);
		queue_req(OP_CREATE, 0, 0);
		queue_req(OP_ALIVE, 0, 0);                          // match
		queue_req(OP_ALIVE, 0, (1 << VER_W) - 1);           // mismatch
		queue_req(OP_GET, 1, 0);
		queue_req(OP_DESTROY, 0, 0);                        // double destroy
		queue_req(OP_DESTROY, 0, 0);
		queue_req(OP_ALIVE, 0, 0);                          // stale handle
		queue_req(OP_CREATE, 0, 0);                         // reuse 0 twice
		queue_req(OP_CREATE, 0, 0);
		queue_req(OP_CREATE, 0, 0);                         // fifo empty, fresh 3
		queue_req(OP_GET, NUM_IDS - 1, 0);
		queue_req(OP_ALIVE, 2, 0);
		queue_req(OP_DESTROY, 3, 0);
		queue_req(OP_GET, 3, 0);
		wait_idle();

		// hold reuse off, hand out a long run of fresh indexes, then free many
		set_min_free(MAX_MIN);
		for (int i = 0; i < BULK_NEW; i++) begin
			queue_req(OP_CREATE, 0, 0);
			if ($urandom_range(0, 9) == 0)
				queue_req(OP_GET, $urandom_range(0, NUM_IDS - 1), 0);
		end
		for (int i = 0; i < BULK_FREE; i++) begin
			queue_req(OP_DESTROY, $urandom_range(0, BULK_NEW + 50), 0);
			if ($urandom_range(0, 9) == 0)
				queue_req(OP_ALIVE, $urandom_range(0, NUM_IDS - 1),
					$urandom_range(0, (1 << VER_W) - 1));
		end
		wait_idle();

		// reuse right away; hammer one index so its version wraps
		set_min_free(0);
		for (int i = 0; i < 300; i++) begin
			queue_req(OP_DESTROY, 7, 0);
			if (i % 50 == 0)
				queue_req(OP_CREATE, 0, 0);
		end
		wait_idle();
		random_reqs(300);
		wait_idle();

		// a small reuse threshold
		set_min_free($urandom_range(1, 40));
		random_reqs(250);
		wait_idle();

		// threshold back at MAX_MIN, which holds reuse off again
		set_min_free(MAX_MIN);
		random_reqs(100);
		wait_idle();

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/gia_pkg.sv
rtl/gia_req_if.sv
rtl/gia_rsp_if.sv
rtl/gia_ctrl.sv
rtl/gia_datapath.sv
rtl/generational_id_allocator_unit.sv
verif/tb.sv
